/* hdl/fsnl_pkg.sv */
// Shared types and constants for the 8.3 short-name directory lookup.
// No dependencies; every other file in hdl/ imports this package.
package fsnl_pkg;

	localparam int NAME_LEN    = 11;
	localparam int EXT_POS     = 8;
	localparam logic [7:0] PAD_CHAR   = 8'h20;
	localparam logic [7:0] DOT_CHAR   = 8'h2E;
	localparam logic [7:0] LOWER_A    = 8'h61;
	localparam logic [7:0] LOWER_Z    = 8'h7A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	localparam logic [15:0] MAX_ENTRIES_RST = 16'd224;
	localparam logic [7:0]  SKIP_ATTR_RST   = 8'h18;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_CHAR  = 2'd1,
		ACT_ENTRY = 2'd2,
		ACT_RSVD  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_NONE  = 3'd0,
		ST_MATCH = 3'd1,
		ST_END   = 3'd2,
		ST_LONG  = 3'd3,
		ST_LIMIT = 3'd4
	} status_t;

	typedef enum logic {
		REG_MAX_ENTRIES = 1'b0,
		REG_SKIP_ATTR   = 1'b1
	} reg_idx_t;

	// Classified item as it travels from front to back.
	typedef struct packed {
		action_t     op;
		logic [7:0]  ch;       // already folded to upper case
		logic        ch_dot;
		logic        ch_zero;
		logic [63:0] head;
		logic [23:0] tail;
		logic [7:0]  attr;
	} item_t;

	typedef struct packed {
		logic [15:0] max_entries;
		logic [7:0]  skip_attr_mask;
	} cfg_t;

endpackage

/* hdl/fat_short_name_lookup_core.sv */
// Top level of the FAT 8.3 short-name directory lookup.
// Depends on fsnl_pkg, fsnl_front, fsnl_queue and fsnl_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per handshake: a
//   query start (action 0), one query name character (action 1) or one
//   directory entry (action 2). Action 3 is accepted and dropped.
//   Characters are folded to upper case into an 11-byte space-padded name;
//   a dot at position 8 or earlier jumps to the extension field.
//   Every directory entry produces exactly one item on the output channel
//   (out_valid/out_ready) with a status and an entry index; once a match,
//   end marker, too-long query or limit is decided, later entries repeat it.
//   An accepted entry first waits in the queue and loads the result register
//   as it leaves the queue, which needs the result slot free (no held
//   result, or out_ready high); the result is then shown on out_valid.
//   Throughput: one item per cycle while the result is not stalled, set by the
//   combinational 88-bit name compare in the back end.
//   A stalled output holds its result; the two-entry queue keeps accepting
//   until full, and characters and query starts drain past a stalled result.
//   Reset clears the query to spaces, all counters and the decision, and
//   loads max_entries = 224 and skip_attr_mask = 0x18.
//   APB registers: 0x0 max_entries, 0x4 skip_attr_mask; write only while idle.
module fat_short_name_lookup_core import fsnl_pkg::*; #(
	parameter int INDEX_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  name_char,
	input  logic [63:0] entry_name_head,
	input  logic [23:0] entry_name_tail,
	input  logic [7:0]  entry_attr,
	// result item channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] entry_index,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	logic  q_full;
	logic  push;
	item_t push_item;
	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	// Register file: word address selects the register, byte offset ignored.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_entries    <= MAX_ENTRIES_RST;
			cfg_q.skip_attr_mask <= SKIP_ATTR_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MAX_ENTRIES: cfg_q.max_entries    <= pwdata[15:0];
				REG_SKIP_ATTR:   cfg_q.skip_attr_mask <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_ENTRIES: prdata = 32'(cfg_q.max_entries);
			REG_SKIP_ATTR:   prdata = 32'(cfg_q.skip_attr_mask);
			default:         prdata = '0;
		endcase
	end

	// Front: classify and fold case, drop reserved actions.
	fsnl_front u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.name_char       (name_char),
		.entry_name_head (entry_name_head),
		.entry_name_tail (entry_name_tail),
		.entry_attr      (entry_attr),
		.q_full          (q_full),
		.push            (push),
		.push_item       (push_item)
	);

	// Queue: decouple the input handshake from result back-pressure.
	fsnl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (q_item)
	);

	// Back: hold the query and search state, drive the result register.
	fsnl_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.entry_index (entry_index)
	);

endmodule

/* hdl/fsnl_front.sv */
// Front end of the lookup: takes input items, classifies them and folds case.
// Depends on fsnl_pkg.
module fsnl_front import fsnl_pkg::*; (
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  name_char,
	input  logic [63:0] entry_name_head,
	input  logic [23:0] entry_name_tail,
	input  logic [7:0]  entry_attr,
	input  logic        q_full,
	output logic        push,
	output item_t       push_item
);

	action_t op;

	always_comb begin
		op                 = action_t'(action);
		push_item.op       = op;
		push_item.ch_dot   = (name_char == DOT_CHAR);
		push_item.ch_zero  = (name_char == 8'h00);
		if ((name_char >= LOWER_A) && (name_char <= LOWER_Z)) begin
			push_item.ch = name_char - CASE_DELTA;
		end else begin
			push_item.ch = name_char;
		end
		push_item.head = entry_name_head;
		push_item.tail = entry_name_tail;
		push_item.attr = entry_attr;
	end

	assign in_ready = !q_full;
	// drop reserved actions here; they never reach the back end
	assign push     = in_valid && !q_full && (op != ACT_RSVD);

endmodule

/* hdl/fsnl_queue.sv */
// Short item queue between the front and back ends of the lookup.
// Depends on fsnl_pkg.
module fsnl_queue import fsnl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t pop_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == DEPTH_CNT);
	assign valid    = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hdl/fsnl_back.sv */
// Back end of the lookup: query name assembly, entry search and result register.
// Depends on fsnl_pkg.
module fsnl_back import fsnl_pkg::*; #(
	parameter int INDEX_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] entry_index
);

	logic [7:0]            query_q [NAME_LEN];
	logic [3:0]            wpos_q;
	logic                  too_long_q;
	logic [INDEX_BITS-1:0] count_q;
	logic                  decided_q;
	status_t               fstat_q;
	logic [INDEX_BITS-1:0] findex_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [INDEX_BITS-1:0] out_index_q;

	logic [8*NAME_LEN-1:0] query_flat;
	logic                  is_entry;
	logic                  out_free;
	logic                  name_eq;
	logic                  decide;
	status_t               new_status;

	always_comb begin
		for (int k = 0; k < NAME_LEN; k++) begin
			query_flat[8*k +: 8] = query_q[k];
		end
	end

	assign is_entry = (q_item.op == ACT_ENTRY);
	assign out_free = !out_valid_q || out_ready;
	// non-entry items need no result slot
	assign q_pop    = q_valid && (!is_entry || out_free);
	assign name_eq  = ({q_item.tail, q_item.head} == query_flat);

	always_comb begin
		decide     = 1'b1;
		new_status = ST_NONE;
		if (too_long_q) begin
			new_status = ST_LONG;
		end else if ((16'(count_q) >= cfg.max_entries) || (count_q == '1)) begin
			new_status = ST_LIMIT;
		end else if (q_item.head[7:0] == 8'h00) begin
			new_status = ST_END;
		end else if (((q_item.attr & cfg.skip_attr_mask) == 8'h00) && name_eq) begin
			new_status = ST_MATCH;
		end else begin
			decide = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NAME_LEN; k++) begin
				query_q[k] <= PAD_CHAR;
			end
			wpos_q      <= '0;
			too_long_q  <= 1'b0;
			count_q     <= '0;
			decided_q   <= 1'b0;
			fstat_q     <= ST_NONE;
			findex_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && is_entry) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				case (q_item.op)
					ACT_CLEAR: begin
						for (int k = 0; k < NAME_LEN; k++) begin
							query_q[k] <= PAD_CHAR;
						end
						wpos_q     <= '0;
						too_long_q <= 1'b0;
						count_q    <= '0;
						decided_q  <= 1'b0;
						fstat_q    <= ST_NONE;
						findex_q   <= '0;
					end
					ACT_CHAR: begin
						if (!q_item.ch_zero && !too_long_q) begin
							if (wpos_q >= 4'(NAME_LEN)) begin
								too_long_q <= 1'b1;
							end else if (q_item.ch_dot && (wpos_q <= 4'(EXT_POS))) begin
								wpos_q <= 4'(EXT_POS);
							end else begin
								for (int k = 0; k < NAME_LEN; k++) begin
									if (wpos_q == 4'(k)) begin
										query_q[k] <= q_item.ch;
									end
								end
								wpos_q <= wpos_q + 4'd1;
							end
						end
					end
					ACT_ENTRY: begin
						if (!decided_q && decide) begin
							decided_q <= 1'b1;
							fstat_q   <= new_status;
							findex_q  <= count_q;
						end else if (!decided_q) begin
							count_q <= count_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result payload, loaded with the entry that takes the slot
	always_ff @(posedge clk) begin
		if (q_pop && is_entry) begin
			if (decided_q) begin
				out_status_q <= fstat_q;
				out_index_q  <= findex_q;
			end else begin
				out_status_q <= new_status;
				out_index_q  <= count_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_index = 16'(out_index_q);

endmodule
